>>> sv/pfr_pkg.sv
// Package for the pulse frame receiver: frame geometry, register indexes
// and the control bundle that drives the row of byte cells. No dependencies.
package pfr_pkg;

   localparam int FRAME_BYTES = 5;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int CNT_W       = $clog2(FRAME_BITS + 1);
   localparam int MAX_BYTES   = 8;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TOL = 2'd1;

   localparam logic [15:0] START_LEN_RST = 16'd2200;
   localparam logic [15:0] START_TOL_RST = 16'd200;

   localparam logic [7:0] HI_NIBBLE = 8'hF0;
   localparam logic [7:0] LO_NIBBLE = 8'h0F;

   typedef struct packed {
      logic clear;   // start of frame: old byte content is dropped
      logic shift;   // a bit is taken this cycle
   } cell_ctl_type;

endpackage

>>> sv/pulse_frame_receiver.sv
// Pulse frame receiver top level: start window check, bit count, the row
// of byte cells and the result register.
// Depends on pfr_pkg and pfr_cell.
//
// Usage:
//   Each req_ beat is one rising edge of the receive line: req_interval_us
//   is the saturated time since the previous edge, req_pin_level the line
//   level sampled after it. An interval strictly inside start length plus
//   or minus tolerance restarts the frame and the same beat's level is the
//   first bit. Forty bits are shifted in most significant first; later
//   bits are dropped until the next start.
//   When the last bit completes a frame whose checksum byte matches the
//   mod-256 sum of the data bytes, one rsp_ beat carries sender id,
//   channel, mode and power. It is valid the cycle after the completing
//   req_ beat is accepted.
//   Throughput: one req_ beat per cycle while req_ready is high. A beat
//   taken into the frame updates all byte cells and the checksum chain
//   in the same cycle. If the receiver stalls, the result waits in the
//   output register and req_ready is low; req_ready drops only while a
//   result is held and rsp_ready is low.
//   The csr_ port writes start length (index 0) and tolerance (index 1);
//   write only while idle. Reset restores 2200 us and 200 us, clears the
//   bit count and the frame and drops any pending result.
module pulse_frame_receiver
   import pfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [15:0]          req_interval_us,
   input  logic                 req_pin_level,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_sender_id,
   output logic [3:0]           rsp_channel,
   output logic [3:0]           rsp_mode,
   output logic [7:0]           rsp_power,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   logic [15:0]      start_len_ff, start_len_in;
   logic [15:0]      start_tol_ff, start_tol_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      sender_id_ff, sender_id_in;
   logic [3:0]       channel_ff, channel_in;
   logic [3:0]       mode_ff, mode_in;
   logic [7:0]       power_ff, power_in;

   logic             accept;
   logic             lo_neg;
   logic [15:0]      lo_bound;
   logic [16:0]      hi_bound;
   logic             is_start;
   logic [CNT_W-1:0] cnt_base;
   logic             take;
   logic             done;
   logic             sum_ok;
   cell_ctl_type     ctl;

   logic [FRAME_BYTES:0]   chain_bit;
   logic [7:0]             sum_chain [FRAME_BYTES+1];
   logic [7:0]             byte_nx   [FRAME_BYTES];
   logic [7:0]             data_pad  [MAX_BYTES];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Window compare without wrap: a negative lower bound lets every interval pass the lower check.
   assign lo_neg   = start_tol_ff > start_len_ff;
   assign lo_bound = start_len_ff - start_tol_ff;
   assign hi_bound = {1'b0, start_len_ff} + {1'b0, start_tol_ff};
   assign is_start = (lo_neg || (req_interval_us > lo_bound))
                     && ({1'b0, req_interval_us} < hi_bound);

   assign cnt_base = is_start ? '0 : cnt_ff;
   assign take     = accept && (cnt_base < CNT_W'(FRAME_BITS));
   assign done     = take && (cnt_base == CNT_W'(FRAME_BITS - 1));

   assign ctl.clear = is_start;
   assign ctl.shift = take;

   // Byte FRAME_BYTES-1 is last on air; new bits enter there.
   assign chain_bit[FRAME_BYTES] = req_pin_level;
   assign sum_chain[0]           = 8'd0;

   for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_cell
      pfr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .bit_in  (chain_bit[g+1]),
         .bit_out (chain_bit[g]),
         .sum_in  (sum_chain[g]),
         .sum_out (sum_chain[g+1]),
         .byte_nx (byte_nx[g])
      );
   end

   // Full-row sum includes the check byte once, so a match means the sum
   // equals twice the check byte modulo 256.
   assign sum_ok = sum_chain[FRAME_BYTES] == {byte_nx[FRAME_BYTES-1][6:0], 1'b0};

   // chain_bit[0] is the bit shifted out of the frame and has no reader.
   for (genvar g = 0; g < MAX_BYTES; g++) begin : g_pad
      if (g < FRAME_BYTES - 1) begin : g_data
         assign data_pad[g] = byte_nx[g];
      end else begin : g_zero
         assign data_pad[g] = 8'd0;
      end
   end

   always_comb begin
      start_len_in = start_len_ff;
      start_tol_in = start_tol_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_LEN: start_len_in = csr_wdata;
            CSR_START_TOL: start_tol_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (take) begin
         cnt_in = cnt_base + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sender_id_in = sender_id_ff;
      channel_in   = channel_ff;
      mode_in      = mode_ff;
      power_in     = power_ff;
      if (done && sum_ok) begin
         rsp_valid_in = 1'b1;
         sender_id_in = {data_pad[1], data_pad[0]};
         channel_in   = 4'((data_pad[2] & HI_NIBBLE) >> 4);
         mode_in      = 4'(data_pad[2] & LO_NIBBLE);
         power_in     = data_pad[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_len_ff <= START_LEN_RST;
         start_tol_ff <= START_TOL_RST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_len_ff <= start_len_in;
         start_tol_ff <= start_tol_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sender_id_ff <= sender_id_in;
      channel_ff   <= channel_in;
      mode_ff      <= mode_in;
      power_ff     <= power_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sender_id = sender_id_ff;
   assign rsp_channel   = channel_ff;
   assign rsp_mode      = mode_ff;
   assign rsp_power     = power_ff;

endmodule

>>> sv/pfr_cell.sv
// One byte cell of the frame shift row. Holds eight frame bits, passes its
// top bit to the neighbor and adds its next byte to the running checksum.
// Depends on pfr_pkg.
module pfr_cell
   import pfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         bit_in,
   output logic         bit_out,
   input  logic [7:0]   sum_in,
   output logic [7:0]   sum_out,
   output logic [7:0]   byte_nx
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic [7:0] base;

   assign base    = ctl.clear ? 8'd0 : byte_ff;
   assign bit_out = base[7];
   assign byte_nx = {base[6:0], bit_in};
   assign sum_out = sum_in + byte_nx;
   assign byte_in = ctl.shift ? byte_nx : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

endmodule

>>> sv/pfr_checker.sv
// Port-level checks for the pulse frame receiver, bound to the top level.
// Depends on pfr_pkg and pulse_frame_receiver.
module pfr_checker
   import pfr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sender_id,
   input logic [3:0]  rsp_channel,
   input logic [3:0]  rsp_mode,
   input logic [7:0]  rsp_power
);

   // A held result keeps its payload until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sender_id)
         && $stable(rsp_channel) && $stable(rsp_mode) && $stable(rsp_power))
      else $error("result changed while stalled");

   // Input backpressure only comes from a stalled result.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a stalled result");

   // A new result needs an accepted input beat in the cycle before.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |-> $past(req_valid && req_ready))
      else $error("result without an input beat");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pulse_frame_receiver pfr_checker u_pfr_checker (.*);
